### hw/rtl/cse_pkg.sv
// shared types, constants and saturating helpers for the cubic spline evaluator
package cse_pkg;

  typedef logic signed [63:0] wide_t;

  localparam wide_t WIDE_LIM = 64'sh0FFF_FFFF_FFFF_FFFF;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW_KNOT = 2'd1;
  localparam logic [1:0] ST_ZERO_INT = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] val;
    logic signed [31:0] slp;
  } knot_t;

  typedef struct packed {
    logic  start;
    logic  is_div;
    wide_t a;
    wide_t b;
  } arith_req_t;

  function automatic wide_t sat_wide(input wide_t s);
    if (s > WIDE_LIM) return WIDE_LIM;
    if (s < -WIDE_LIM) return -WIDE_LIM;
    return s;
  endfunction

  function automatic wide_t sadd(input wide_t a, input wide_t b);
    return sat_wide(a + b);
  endfunction

  function automatic wide_t ssub(input wide_t a, input wide_t b);
    return sat_wide(a - b);
  endfunction

  function automatic logic signed [31:0] out32(input wide_t v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### hw/rtl/cse_ifs.sv
// valid/ready channel interfaces for input and result words
interface cse_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         knot_index;
  logic signed [31:0] knot_position;
  logic signed [31:0] knot_value;
  logic signed [31:0] knot_slope;
  logic signed [31:0] query_position;

  modport source(output valid, action, knot_index, knot_position, knot_value, knot_slope,
                 query_position, input ready);
  modport sink(input valid, action, knot_index, knot_position, knot_value, knot_slope,
               query_position, output ready);
endinterface

interface cse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_value;
  logic signed [31:0] first_derivative;
  logic signed [31:0] second_derivative;
  logic [1:0]         status;

  modport source(output valid, curve_value, first_derivative, second_derivative, status,
                 input ready);
  modport sink(input valid, curve_value, first_derivative, second_derivative, status,
               output ready);
endinterface

### hw/rtl/cse_knot_mem.sv
// knot table memory, one write port and one registered read port
module cse_knot_mem
  import cse_pkg::*;
#(
  parameter int MAX_KNOTS = 256,
  parameter int AW        = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  knot_t         wdata,
  input  logic [AW-1:0] raddr,
  output knot_t         rdata
);

  knot_t mem [MAX_KNOTS];
  knot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/cse_arith.sv
// shared saturating fixed-point multiply and divide unit, multi-cycle
module cse_arith
  import cse_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output logic       done,
  output wide_t      result
);

  localparam int DN = 64 + FRAC_BITS;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_t;

  astate_t          state_r;
  logic             is_div_r;
  logic             neg_r;
  logic [63:0]      ua_r;
  logic [63:0]      ub_r;
  logic [127:0]     acc_r;
  logic [DN-1:0]    num_r;
  logic [DN-1:0]    quo_r;
  logic [63:0]      rem_r;
  logic [6:0]       cnt_r;
  logic             done_r;
  wide_t            result_r;

  logic [63:0]  ua, ub;
  logic [31:0]  mx, my;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  r2;
  logic [127:0] mshift;
  logic [DN-1:0] lim_dn;
  logic [63:0]  mag;

  assign ua = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign ub = req.b[63] ? 64'(-req.b) : 64'(req.b);

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    mx = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    my = (cnt_r[1:0] == 2'd1 || cnt_r[1:0] == 2'd3) ? ub_r[63:32] : ub_r[31:0];
    pp = 64'(mx) * 64'(my);
    unique case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign r2     = {rem_r, num_r[DN-1]};
  assign mshift = acc_r >> FRAC_BITS;
  assign lim_dn = DN'(WIDE_LIM);

  always_comb begin
    if (is_div_r) begin
      mag = (quo_r > lim_dn) ? 64'(WIDE_LIM) : quo_r[63:0];
    end else begin
      mag = (mshift > 128'(WIDE_LIM)) ? 64'(WIDE_LIM) : mshift[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        A_IDLE: begin
          if (req.start) begin
            ua_r     <= ua;
            ub_r     <= ub;
            neg_r    <= req.a[63] ^ req.b[63];
            is_div_r <= req.is_div;
            acc_r    <= '0;
            num_r    <= DN'(ua) << FRAC_BITS;
            quo_r    <= '0;
            rem_r    <= '0;
            cnt_r    <= '0;
            state_r  <= req.is_div ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          acc_r <= acc_r + pp_sh;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[1:0] == 2'd3) state_r <= A_FIN;
        end
        A_DIV: begin
          num_r <= num_r << 1;
          if (r2 >= {1'b0, ub_r}) begin
            rem_r <= 64'(r2 - {1'b0, ub_r});
            quo_r <= {quo_r[DN-2:0], 1'b1};
          end else begin
            rem_r <= r2[63:0];
            quo_r <= {quo_r[DN-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DN - 1)) state_r <= A_FIN;
        end
        A_FIN: begin
          result_r <= neg_r ? -wide_t'(mag) : wide_t'(mag);
          done_r   <= 1'b1;
          state_r  <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

### hw/rtl/cubic_spline_evaluator_unit.sv
// top level of the cubic hermite spline evaluator
// a knot write word is written to the knot memory in the cycle it is
// accepted. an evaluate word works through the knot memory (one registered
// read port) and then through one shared multiply/divide unit: the interval
// search probes the table for the lower bound, then the two knots are
// fetched; the evaluation then issues 16 multiplies (four 32x32 partial
// products each) and 4 divides (one quotient bit per cycle). too few knots
// or a zero-length interval finish early with a status code and zero
// outputs. one word is in work at a time; a finished result sits in an
// output register, and input is taken again while it waits. the table has
// no reset: read only entries that were written.
module cubic_spline_evaluator_unit
  import cse_pkg::*;
#(
  parameter int MAX_KNOTS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  cse_in_if.sink     in_ch,
  cse_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam wide_t Q_ONE   = wide_t'(64'd1 << FRAC_BITS);
  localparam wide_t Q_TWO   = wide_t'(64'd2 << FRAC_BITS);
  localparam wide_t Q_THREE = wide_t'(64'd3 << FRAC_BITS);
  localparam wide_t Q_FOUR  = wide_t'(64'd4 << FRAC_BITS);
  localparam wide_t Q_SIX   = wide_t'(64'd6 << FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_ADDR, S_SRCH_CMP, S_RD_LO, S_RD_HI, S_RD_LAST,
    S_CALC_ISSUE, S_CALC_WAIT, S_DONE
  } state_t;

  // evaluation steps, one multiply or divide each
  typedef enum logic [4:0] {
    OP_T, OP_C0, OP_C1, OP_TT, OP_KA, OP_KB, OP_VE, OP_VF, OP_DG, OP_DH,
    OP_DI, OP_DJ, OP_DL, OP_DM, OP_DQ, OP_SP, OP_SU, OP_SW, OP_S1, OP_S2
  } step_t;

  state_t             state_r;
  step_t              step_r;
  logic [8:0]         knot_count_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      lo_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] query_r;
  knot_t              k0_r;
  logic [1:0]         status_r;
  wide_t              ds_r, dx_r, t_r, tt_r, c0_r, c1_r, k_r, tmp_r, v_r, dd_r, p_r, sec_r;

  logic               out_valid_r;
  logic signed [31:0] res_value_r, res_deriv_r, res_second_r;
  logic [1:0]         res_status_r;

  // memory hookup
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  knot_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  knot_t         mem_rdata;
  logic [31:0]   widx;

  // arithmetic unit hookup
  arith_req_t areq;
  logic       adone;
  wide_t      ares;

  logic          in_acc;
  logic [31:0]   kc32;
  logic [31:0]   n32;
  logic [CW-1:0] step_half;
  logic [CW-1:0] probe;
  logic [CW-1:0] lo_clamp;
  wide_t         ds_new;
  wide_t         k0_pos, k0_val, k0_slp;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // knot write goes straight to the memory
  assign widx      = {24'd0, in_ch.knot_index};
  assign mem_we    = in_acc && (in_ch.action == ACT_WRITE) && (widx < 32'(MAX_KNOTS));
  assign mem_waddr = widx[AW-1:0];
  assign mem_wdata = '{pos: in_ch.knot_position, val: in_ch.knot_value,
                       slp: in_ch.knot_slope};

  // counts above the table depth act as the depth
  assign kc32 = {23'd0, knot_count_r};
  assign n32  = (kc32 > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : kc32;

  assign step_half = cnt_r >> 1;
  assign probe     = lo_r + step_half;

  // clamp the lower bound into the first..last interval
  always_comb begin
    if (lo_r < CW'(1)) lo_clamp = CW'(1);
    else if (lo_r > n_r - CW'(1)) lo_clamp = n_r - CW'(1);
    else lo_clamp = lo_r;
  end

  always_comb begin
    unique case (state_r)
      S_SRCH_ADDR: mem_raddr = probe[AW-1:0];
      S_SRCH_CMP:  mem_raddr = probe[AW-1:0];
      S_RD_LO:     mem_raddr = AW'(lo_r - CW'(1));
      default:     mem_raddr = lo_r[AW-1:0];
    endcase
  end

  assign k0_pos = wide_t'(k0_r.pos);
  assign k0_val = wide_t'(k0_r.val);
  assign k0_slp = wide_t'(k0_r.slp);
  assign ds_new = wide_t'(mem_rdata.pos) - k0_pos;

  // operand selection for each evaluation step
  always_comb begin
    areq.start  = (state_r == S_CALC_ISSUE);
    areq.is_div = 1'b0;
    areq.a      = '0;
    areq.b      = '0;
    unique case (step_r)
      OP_T: begin
        areq.is_div = 1'b1;
        areq.a      = wide_t'(query_r) - k0_pos;
        areq.b      = ds_r;
      end
      OP_C0: begin areq.a = ds_r; areq.b = k0_slp; end
      OP_C1: begin areq.a = ds_r; areq.b = c1_r; end
      OP_TT: begin areq.a = t_r; areq.b = t_r; end
      OP_KA: begin areq.a = ssub(Q_ONE, t_r); areq.b = c0_r; end
      OP_KB: begin areq.a = t_r; areq.b = c1_r; end
      OP_VE: begin areq.a = t_r; areq.b = dx_r; end
      OP_VF: begin areq.a = ssub(t_r, tt_r); areq.b = k_r; end
      OP_DG: begin areq.a = Q_FOUR; areq.b = t_r; end
      OP_DH: begin areq.a = Q_THREE; areq.b = tt_r; end
      OP_DI: begin areq.a = k_r; areq.b = c0_r; end
      OP_DJ: begin areq.a = Q_THREE; areq.b = t_r; end
      OP_DL: begin areq.a = t_r; areq.b = ssub(tmp_r, Q_TWO); end
      OP_DM: begin areq.a = tmp_r; areq.b = c1_r; end
      OP_DQ: begin areq.is_div = 1'b1; areq.a = dd_r; areq.b = ds_r; end
      OP_SP: begin areq.a = Q_SIX; areq.b = t_r; end
      OP_SU: begin areq.a = ssub(p_r, Q_FOUR); areq.b = c0_r; end
      OP_SW: begin areq.a = ssub(p_r, Q_TWO); areq.b = c1_r; end
      OP_S1: begin areq.is_div = 1'b1; areq.a = sec_r; areq.b = ds_r; end
      OP_S2: begin areq.is_div = 1'b1; areq.a = sec_r; areq.b = ds_r; end
      default: begin areq.a = '0; areq.b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= OP_T;
      knot_count_r <= 9'd2;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) knot_count_r <= cfg_wdata;
      // in S_DONE a taken result word is replaced by the next one below
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.action == ACT_EVAL) begin
            query_r <= in_ch.query_position;
            n_r     <= n32[CW-1:0];
            lo_r    <= '0;
            cnt_r   <= n32[CW-1:0];
            if (n32 < 32'd2) begin
              status_r <= ST_FEW_KNOT;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_SRCH_ADDR;
            end
          end
        end
        // lower-bound search, S_SRCH_ADDR then S_SRCH_CMP for each probe
        S_SRCH_ADDR: begin
          if (cnt_r == '0) begin
            lo_r    <= lo_clamp;
            state_r <= S_RD_LO;
          end else begin
            state_r <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (mem_rdata.pos < query_r) begin
            lo_r  <= probe + CW'(1);
            cnt_r <= cnt_r - step_half - CW'(1);
          end else begin
            cnt_r <= step_half;
          end
          state_r <= S_SRCH_ADDR;
        end
        S_RD_LO: state_r <= S_RD_HI;
        S_RD_HI: begin
          k0_r    <= mem_rdata;
          state_r <= S_RD_LAST;
        end
        S_RD_LAST: begin
          ds_r   <= ds_new;
          dx_r   <= wide_t'(mem_rdata.val) - wide_t'(k0_r.val);
          c1_r   <= wide_t'(mem_rdata.slp);
          step_r <= OP_T;
          if (ds_new == '0) begin
            status_r <= ST_ZERO_INT;
            state_r  <= S_DONE;
          end else begin
            status_r <= ST_OK;
            state_r  <= S_CALC_ISSUE;
          end
        end
        S_CALC_ISSUE: state_r <= S_CALC_WAIT;
        S_CALC_WAIT: begin
          if (adone) begin
            unique case (step_r)
              OP_T:  t_r   <= ares;
              OP_C0: c0_r  <= ssub(ares, dx_r);
              OP_C1: c1_r  <= ssub(ares, dx_r);
              OP_TT: tt_r  <= ares;
              OP_KA: tmp_r <= ares;
              OP_KB: k_r   <= ssub(tmp_r, ares);
              OP_VE: v_r   <= sadd(k0_val, ares);
              OP_VF: v_r   <= sadd(v_r, ares);
              OP_DG: tmp_r <= ssub(Q_ONE, ares);
              OP_DH: k_r   <= sadd(tmp_r, ares);
              OP_DI: dd_r  <= sadd(dx_r, ares);
              OP_DJ: tmp_r <= ares;
              OP_DL: tmp_r <= ares;
              OP_DM: dd_r  <= sadd(dd_r, ares);
              OP_DQ: dd_r  <= ares;
              OP_SP: p_r   <= ares;
              OP_SU: tmp_r <= ares;
              OP_SW: sec_r <= sadd(tmp_r, ares);
              OP_S1: sec_r <= ares;
              OP_S2: sec_r <= ares;
              default: tmp_r <= ares;
            endcase
            if (step_r == OP_S2) begin
              state_r <= S_DONE;
            end else begin
              step_r  <= step_t'(step_r + 5'd1);
              state_r <= S_CALC_ISSUE;
            end
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            res_status_r <= status_r;
            if (status_r == ST_OK) begin
              res_value_r  <= out32(v_r);
              res_deriv_r  <= out32(dd_r);
              res_second_r <= out32(sec_r);
            end else begin
              res_value_r  <= '0;
              res_deriv_r  <= '0;
              res_second_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.curve_value       = res_value_r;
  assign out_ch.first_derivative  = res_deriv_r;
  assign out_ch.second_derivative = res_second_r;
  assign out_ch.status            = res_status_r;

  cse_knot_mem #(
    .MAX_KNOTS(MAX_KNOTS),
    .AW       (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  cse_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .done  (adone),
    .result(ares)
  );

endmodule

### tb/tb_cubic_spline_evaluator_unit.sv
// self-checking testbench for the cubic spline evaluator top level
module tb_cubic_spline_evaluator_unit;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOTS = 256;
  localparam int FRAC = 16;
  localparam int TARGET_WORDS = 850;
  localparam longint CYCLE_LIMIT = 2000000;
  // long enough to cover one evaluate plus a write
  localparam int DRAIN_CYCLES = 800;

  typedef struct {
    logic               action;
    logic [7:0]         knot_index;
    logic signed [31:0] knot_position;
    logic signed [31:0] knot_value;
    logic signed [31:0] knot_slope;
    logic signed [31:0] query_position;
  } word_t;

  typedef struct {
    logic signed [31:0] curve_value;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic [1:0]         status;
  } result_t;

  // knot table mirror, spline arithmetic and the queue of pending results
  class spline_board;
    logic signed [31:0] pos_tab[KNOTS];
    logic signed [31:0] val_tab[KNOTS];
    logic signed [31:0] slp_tab[KNOTS];
    int unsigned knot_count;
    result_t pending[$];
    int errors;

    function new();
      knot_count = 2;
      errors = 0;
    endfunction

    function wide_t clip(input logic signed [65:0] s);
      if (s > WIDE_LIM) return WIDE_LIM;
      if (s < -WIDE_LIM) return -WIDE_LIM;
      return wide_t'(s);
    endfunction

    function wide_t add_s(input wide_t a, input wide_t b);
      return clip(66'(a) + 66'(b));
    endfunction

    function wide_t sub_s(input wide_t a, input wide_t b);
      return clip(66'(a) - 66'(b));
    endfunction

    function logic [63:0] mag(input wide_t a);
      return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function wide_t signed_lim(input logic neg, input logic [127:0] m);
      wide_t r;
      r = (m > 128'(WIDE_LIM)) ? WIDE_LIM : wide_t'(m[63:0]);
      return neg ? -r : r;
    endfunction

    // q16 product, truncated toward zero
    function wide_t mul_q(input wide_t a, input wide_t b);
      logic [127:0] p;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      return signed_lim(a[63] ^ b[63], p >> FRAC);
    endfunction

    // q16 quotient, truncated toward zero; b is nonzero
    function wide_t div_q(input wide_t a, input wide_t b);
      logic [127:0] n;
      n = {64'b0, mag(a)} << FRAC;
      return signed_lim(a[63] ^ b[63], n / {64'b0, mag(b)});
    endfunction

    function logic signed [31:0] to32(input wide_t v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function result_t evaluate(input logic signed [31:0] q);
      result_t r;
      int unsigned n, lo, cnt, step;
      wide_t one, s0, ds, x0, dx, t, c0, c1, tt, v, d, sec, k;
      one = 64'sd1 <<< FRAC;
      r = '{default: '0};
      n = (knot_count > KNOTS) ? KNOTS : knot_count;
      if (n < 2) begin
        r.status = ST_FEW_KNOT;
        return r;
      end
      // lower-bound search over the used knots
      lo = 0;
      cnt = n;
      while (cnt > 0) begin
        step = cnt / 2;
        if (pos_tab[lo + step] < q) begin
          lo += step + 1;
          cnt -= step + 1;
        end else begin
          cnt = step;
        end
      end
      if (lo < 1) lo = 1;
      if (lo > n - 1) lo = n - 1;
      s0 = pos_tab[lo - 1];
      ds = wide_t'(pos_tab[lo]) - s0;
      if (ds == 0) begin
        r.status = ST_ZERO_INT;
        return r;
      end
      x0 = val_tab[lo - 1];
      dx = wide_t'(val_tab[lo]) - x0;
      t = div_q(wide_t'(q) - s0, ds);
      c0 = sub_s(mul_q(ds, slp_tab[lo - 1]), dx);
      c1 = sub_s(mul_q(ds, slp_tab[lo]), dx);
      tt = mul_q(t, t);
      k = sub_s(mul_q(sub_s(one, t), c0), mul_q(t, c1));
      v = add_s(add_s(x0, mul_q(t, dx)), mul_q(sub_s(t, tt), k));
      k = add_s(sub_s(one, mul_q(4 * one, t)), mul_q(3 * one, tt));
      d = add_s(dx, mul_q(k, c0));
      d = add_s(d, mul_q(mul_q(t, sub_s(mul_q(3 * one, t), 2 * one)), c1));
      d = div_q(d, ds);
      sec = add_s(mul_q(sub_s(mul_q(6 * one, t), 4 * one), c0),
                  mul_q(sub_s(mul_q(6 * one, t), 2 * one), c1));
      sec = div_q(div_q(sec, ds), ds);
      r.curve_value = to32(v);
      r.first_derivative = to32(d);
      r.second_derivative = to32(sec);
      r.status = ST_OK;
      return r;
    endfunction

    function void note_word(input word_t w);
      if (w.action == ACT_WRITE) begin
        pos_tab[w.knot_index] = w.knot_position;
        val_tab[w.knot_index] = w.knot_value;
        slp_tab[w.knot_index] = w.knot_slope;
      end else begin
        pending.push_back(evaluate(w.query_position));
      end
    endfunction

    function void check_result(input result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, got value %h deriv %h second %h status %0d",
                 $time, got.curve_value, got.first_derivative, got.second_derivative,
                 got.status);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.curve_value !== exp_r.curve_value) begin
        $display("%0t: curve_value expected %h actual %h", $time, exp_r.curve_value,
                 got.curve_value);
        errors++;
      end
      if (got.first_derivative !== exp_r.first_derivative) begin
        $display("%0t: first_derivative expected %h actual %h", $time,
                 exp_r.first_derivative, got.first_derivative);
        errors++;
      end
      if (got.second_derivative !== exp_r.second_derivative) begin
        $display("%0t: second_derivative expected %h actual %h", $time,
                 exp_r.second_derivative, got.second_derivative);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;

  cse_in_if in_ch();
  cse_out_if out_ch();

  cubic_spline_evaluator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  spline_board board = new();

  // no idling on either side while set
  bit calm = 1'b0;
  // asks the result side for one long hold-off
  bit hold_req = 1'b0;
  int words_sent = 0;
  longint cycles = 0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.knot_index = '0;
    in_ch.knot_position = '0;
    in_ch.knot_value = '0;
    in_ch.knot_slope = '0;
    in_ch.query_position = '0;
    out_ch.ready = 1'b0;
  end

  // cycle limit watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_cubic_spline_evaluator_unit: done, errors");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_ready
    int held;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < 3000; held++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_result('{out_ch.curve_value, out_ch.first_derivative,
                           out_ch.second_derivative, out_ch.status});
    end
  end

  // offer one word, at times with a random gap ahead of it
  task automatic send_word(input word_t w);
    if (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= w.action;
    in_ch.knot_index <= w.knot_index;
    in_ch.knot_position <= w.knot_position;
    in_ch.knot_value <= w.knot_value;
    in_ch.knot_slope <= w.knot_slope;
    in_ch.query_position <= w.query_position;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic write_knot(input int idx, input logic signed [31:0] p,
                            input logic signed [31:0] v, input logic signed [31:0] s);
    word_t w;
    w = '{ACT_WRITE, 8'(idx), p, v, s, 32'($urandom)};
    send_word(w);
  endtask

  task automatic query(input logic signed [31:0] q);
    word_t w;
    w = '{ACT_EVAL, 8'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), q};
    send_word(w);
  endtask

  // register writes only once every result is out and the last word retired
  task automatic set_count(input int unsigned c);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 9'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.knot_count = c;
  endtask

  // value or slope: mostly moderate, sometimes any 32-bit word or an extreme
  function automatic logic signed [31:0] pick_data();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  // reload the first n knots; mode picks ordering of the positions
  task automatic load_table(input int n, input int mode);
    longint p, gap;
    int i;
    gap = (mode == 1) ? 64'd16000000 : 64'd300000;
    p = -longint'(n) * gap / 2 + $signed($urandom_range(0, 2000000)) - 1000000;
    for (i = 0; i < n; i++) begin
      case (mode)
        2: write_knot(i, 32'($urandom), pick_data(), pick_data());
        default: begin
          if (p > 64'sd2147483647) p = 64'sd2147483647;
          write_knot(i, 32'(p), pick_data(), pick_data());
          // duplicates now and then in mode three
          if (!(mode == 3 && $urandom_range(3) == 0))
            p += 1 + $urandom_range(0, 32'(gap));
        end
      endcase
    end
  endtask

  // query inside, on, or outside the used span
  function automatic logic signed [31:0] pick_query(input int n);
    int i;
    longint lo_p, hi_p;
    i = $urandom_range(0, n - 1);
    lo_p = board.pos_tab[0];
    hi_p = board.pos_tab[n - 1];
    case ($urandom_range(9))
      0: return board.pos_tab[i];
      1: return 32'($urandom);
      2: return 32'sh8000_0000;
      3: return 32'sh7FFF_FFFF;
      default: begin
        if (hi_p < lo_p) return 32'($urandom);
        return 32'(lo_p + longint'($urandom_range(0, 32'(hi_p - lo_p + 200000))) - 100000);
      end
    endcase
  endfunction

  initial begin : stimulus
    int i, n, phase, mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table once so every search reads written entries
    calm = 1'b1;
    load_table(KNOTS, 0);
    calm = 1'b0;

    // directed: default count, field extremes below and above the span, and on both knots
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    query(board.pos_tab[1]);
    query(board.pos_tab[0]);
    // too few knots
    set_count(0);
    query(32'sd0);
    set_count(1);
    query(32'sd12345);
    // full table and a count beyond it
    set_count(256);
    query(board.pos_tab[128]);
    query(32'sh7FFF_FFFF);
    set_count(511);
    query(board.pos_tab[255]);
    query(32'sh8000_0000);
    // zero-length interval
    set_count(2);
    write_knot(0, 32'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000);
    write_knot(1, 32'sd65536, 32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sd65536);
    // descending pair gives negative interval length
    write_knot(0, 32'sd196608, 32'sd65536, 32'sd0);
    write_knot(1, 32'sd65536, -32'sd65536, 32'sd131072);
    query(32'sd131072);
    // extreme knots, saturating arithmetic
    write_knot(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_knot(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    query(32'sd0);
    query(32'sh8000_0000);

    // random phases
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      case ($urandom_range(9))
        0: n = (phase % 2) ? 256 : 511;
        1: n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 16);
      endcase
      set_count(n);
      if (n >= 2) begin
        mode = $urandom_range(9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
        if (n <= 16 || $urandom_range(3) == 0) load_table(n > KNOTS ? KNOTS : n, mode);
      end
      calm = (phase == 3);
      if (phase == 5) hold_req = 1'b1;
      for (i = 0; i < 24; i++) begin
        if (n >= 2 && $urandom_range(9) < 3) begin
          // refresh one knot; its position mostly kept so order survives
          int k;
          k = $urandom_range(0, (n > KNOTS ? KNOTS : n) - 1);
          write_knot(k, ($urandom_range(9) == 0) ? 32'($urandom) : board.pos_tab[k],
                     pick_data(), pick_data());
        end else begin
          query(pick_query(n < 2 ? 2 : (n > KNOTS ? KNOTS : n)));
        end
      end
      calm = 1'b0;
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_cubic_spline_evaluator_unit: done, clean");
    end else begin
      $display("tb_cubic_spline_evaluator_unit: done, errors");
    end
    $finish;
  end

endmodule

### cubic_spline_evaluator_unit.f
hw/rtl/cse_pkg.sv
hw/rtl/cse_ifs.sv
hw/rtl/cse_knot_mem.sv
hw/rtl/cse_arith.sv
hw/rtl/cubic_spline_evaluator_unit.sv
tb/tb_cubic_spline_evaluator_unit.sv
